// ===== rtl/sroc_pkg.sv =====
// sroc_pkg: shared types and constants of the segment raster overlap counter
// holds command and result formats, status and operation codes, back-end states
// no dependencies
package sroc_pkg;

    localparam int COORD_W  = 10;
    localparam int COUNT_W  = 21;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    // register index of skip_diagonals
    localparam logic [ADDR_W-3:0] REG_SKIP_DIAG = '0;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_SKIPPED  = 2'd1,
        ST_REJECTED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_NONE  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        DIR_ZERO = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        BK_INIT  = 3'd0,
        BK_IDLE  = 3'd1,
        BK_WALK  = 3'd2,
        BK_CLEAR = 3'd3
    } t_back_state;

    typedef struct packed {
        t_op                op;
        t_status            status;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        t_dir               dir_x;
        t_dir               dir_y;
        logic [COORD_W-1:0] steps;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_result;

    function automatic logic [COORD_W-1:0] dir_step(input t_dir d);
        logic [COORD_W-1:0] s;
        case (d)
            DIR_POS: s = COORD_W'(1);
            DIR_NEG: s = '1;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/segment_raster_overlap_counter.sv =====
// segment_raster_overlap_counter: counts grid cells hit by two or more segments
// a segment of n+1 cells is walked with one cell read-modify-write per cycle through
// the row memory port; a clear zeroes every row, a skipped or rejected item gets its
// result straight from the idle state; items run one at a time
// after reset full stays high while every row is zeroed
// depends on sroc_pkg, sroc_front, sroc_fifo, sroc_back
module segment_raster_overlap_counter #(
    parameter int GRID_DIM = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sroc_pkg::ADDR_W-1:0]   paddr,
    input  logic [sroc_pkg::DATA_W-1:0]   pwdata,
    output logic [sroc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_action,
    input  logic [sroc_pkg::COORD_W-1:0]  i_start_x,
    input  logic [sroc_pkg::COORD_W-1:0]  i_start_y,
    input  logic [sroc_pkg::COORD_W-1:0]  i_end_x,
    input  logic [sroc_pkg::COORD_W-1:0]  i_end_y,
    output logic                          empty,
    input  logic                          pop,
    output logic [sroc_pkg::COUNT_W-1:0]  o_overlap_count,
    output logic [sroc_pkg::STATUS_W-1:0] o_status
);
    import sroc_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    logic             r_skip_diag;
    logic             w_reg_hit;
    logic             w_cmd_push, w_cmd_full, w_cmd_empty, w_cmd_pop;
    logic             w_init_busy;
    t_cmd             w_cmd_in, w_cmd_out;
    logic [CMD_W-1:0] w_cmd_out_bits;
    logic             w_res_push, w_res_full;
    t_result          w_res_in, w_res_out;
    logic [RES_W-1:0] w_res_out_bits;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[ADDR_W-1:2] == REG_SKIP_DIAG);
    assign prdata    = w_reg_hit ? {{(DATA_W - 1){1'b0}}, r_skip_diag} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_diag <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_skip_diag <= pwdata[0];
        end
    end

    sroc_front u_front (
        .i_push      (push),
        .i_action    (i_action),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_skip_diag (r_skip_diag),
        .i_cmd_full  (w_cmd_full),
        .i_init_busy (w_init_busy),
        .o_full      (full),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_cmd_in)
    );

    sroc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out_bits),
        .o_empty (w_cmd_empty)
    );

    assign w_cmd_out = t_cmd'(w_cmd_out_bits);

    sroc_back #(
        .GRID_DIM (GRID_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .o_init_busy (w_init_busy)
    );

    sroc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out_bits),
        .o_empty (empty)
    );

    assign w_res_out       = t_result'(w_res_out_bits);
    assign o_overlap_count = w_res_out.count;
    assign o_status        = w_res_out.status;

endmodule

// ===== rtl/sroc_fifo.sv =====
// sroc_fifo: small register queue with push/pop and full/empty flags
// used between front and back and for waiting results; no package needed
module sroc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/sroc_front.sv =====
// sroc_front: accepts segment items and classifies them into back-end commands
// depends on sroc_pkg for the command format and codes
module sroc_front (
    input  logic                         i_push,
    input  logic                         i_action,
    input  logic [sroc_pkg::COORD_W-1:0] i_start_x,
    input  logic [sroc_pkg::COORD_W-1:0] i_start_y,
    input  logic [sroc_pkg::COORD_W-1:0] i_end_x,
    input  logic [sroc_pkg::COORD_W-1:0] i_end_y,
    input  logic                         i_skip_diag,
    input  logic                         i_cmd_full,
    input  logic                         i_init_busy,
    output logic                         o_full,
    output logic                         o_cmd_push,
    output sroc_pkg::t_cmd               o_cmd
);
    import sroc_pkg::*;

    logic [COORD_W-1:0] w_adx, w_ady;
    t_dir               w_dir_x, w_dir_y;
    logic               w_diag;

    assign o_full     = i_cmd_full || i_init_busy;
    assign o_cmd_push = i_push && !o_full;

    always_comb begin
        if (i_end_x > i_start_x) begin
            w_dir_x = DIR_POS;
            w_adx   = i_end_x - i_start_x;
        end else if (i_end_x < i_start_x) begin
            w_dir_x = DIR_NEG;
            w_adx   = i_start_x - i_end_x;
        end else begin
            w_dir_x = DIR_ZERO;
            w_adx   = '0;
        end
        if (i_end_y > i_start_y) begin
            w_dir_y = DIR_POS;
            w_ady   = i_end_y - i_start_y;
        end else if (i_end_y < i_start_y) begin
            w_dir_y = DIR_NEG;
            w_ady   = i_start_y - i_end_y;
        end else begin
            w_dir_y = DIR_ZERO;
            w_ady   = '0;
        end
        w_diag = (w_dir_x != DIR_ZERO) && (w_dir_y != DIR_ZERO);
    end

    always_comb begin
        o_cmd.x      = i_start_x;
        o_cmd.y      = i_start_y;
        o_cmd.dir_x  = w_dir_x;
        o_cmd.dir_y  = w_dir_y;
        o_cmd.steps  = (w_adx > w_ady) ? w_adx : w_ady;
        o_cmd.op     = OP_DRAW;
        o_cmd.status = ST_DONE;
        if (i_action) begin
            o_cmd.op = OP_CLEAR;
        end else if (w_diag && (w_adx != w_ady)) begin
            o_cmd.op     = OP_NONE;
            o_cmd.status = ST_REJECTED;
        end else if (w_diag && i_skip_diag) begin
            o_cmd.op     = OP_NONE;
            o_cmd.status = ST_SKIPPED;
        end
    end

endmodule

// ===== rtl/sroc_back.sv =====
// sroc_back: walks segments over the row-wide cell memory, sweeps it after reset and on clear
// depends on sroc_pkg for commands, results and states
module sroc_back #(
    parameter int GRID_DIM = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sroc_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output sroc_pkg::t_result o_res,
    output logic              o_init_busy
);
    import sroc_pkg::*;

    localparam int IDX_W = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
    localparam int CMP_W = $clog2(GRID_DIM + 1);
    localparam int EXT_W = (CMP_W > COORD_W) ? CMP_W : COORD_W;
    localparam int ROW_W = 2 * GRID_DIM;
    localparam logic [EXT_W-1:0] DIM_EXT  = EXT_W'(GRID_DIM);
    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(GRID_DIM - 1);

    // one memory word per grid row, two bits per cell
    logic [ROW_W-1:0] mem [GRID_DIM];

    t_back_state        r_state, n_state;
    logic [IDX_W-1:0]   r_clr_row, n_clr_row;
    logic [COORD_W-1:0] r_x, n_x, r_y, n_y;
    t_dir               r_dir_x, n_dir_x, r_dir_y, n_dir_y;
    logic [COORD_W:0]   r_left, n_left;
    logic               r_s2_valid, n_s2_valid;
    logic [IDX_W-1:0]   r_s2_col, n_s2_col, r_s2_row, n_s2_row;
    logic [ROW_W-1:0]   r_rd_data;
    logic               r_fwd_valid, n_fwd_valid;
    logic [IDX_W-1:0]   r_fwd_row, n_fwd_row;
    logic [ROW_W-1:0]   r_fwd_data, n_fwd_data;
    logic [COUNT_W-1:0] r_count, n_count;

    logic               w_take;
    logic               w_rd_en, w_wr_en;
    logic [IDX_W-1:0]   w_rd_addr, w_wr_addr;
    logic [ROW_W-1:0]   w_wr_data;
    logic [EXT_W-1:0]   w_x_ext, w_y_ext;
    logic               w_in_grid;
    logic [ROW_W-1:0]   w_base;
    logic [1:0]         w_old;
    logic [ROW_W-1:0]   w_new_row;

    assign w_take      = (r_state == BK_IDLE) && !i_cmd_empty && !i_res_full;
    assign o_init_busy = (r_state == BK_INIT);

    assign w_x_ext   = EXT_W'(r_x);
    assign w_y_ext   = EXT_W'(r_y);
    assign w_in_grid = (w_x_ext < DIM_EXT) && (w_y_ext < DIM_EXT);

    // newest copy of the row: last written row wins over the memory read
    always_comb begin
        w_base    = (r_fwd_valid && (r_fwd_row == r_s2_row)) ? r_fwd_data : r_rd_data;
        w_old     = w_base[{r_s2_col, 1'b0} +: 2];
        w_new_row = w_base;
        w_new_row[{r_s2_col, 1'b0} +: 2] = w_old + 2'd1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_INIT: begin
                if (r_clr_row == LAST_ROW) n_state = BK_IDLE;
            end
            BK_IDLE: begin
                if (w_take) begin
                    case (i_cmd.op)
                        OP_DRAW:  n_state = BK_WALK;
                        OP_CLEAR: n_state = BK_CLEAR;
                        default:  n_state = BK_IDLE;
                    endcase
                end
            end
            BK_WALK: begin
                if ((r_left == '0) && !r_s2_valid) n_state = BK_IDLE;
            end
            BK_CLEAR: begin
                if (r_clr_row == LAST_ROW) n_state = BK_IDLE;
            end
            default: n_state = BK_INIT;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_clr_row   = r_clr_row;
        n_x         = r_x;
        n_y         = r_y;
        n_dir_x     = r_dir_x;
        n_dir_y     = r_dir_y;
        n_left      = r_left;
        n_s2_valid  = 1'b0;
        n_s2_col    = r_s2_col;
        n_s2_row    = r_s2_row;
        n_fwd_valid = r_fwd_valid;
        n_fwd_row   = r_fwd_row;
        n_fwd_data  = r_fwd_data;
        n_count     = r_count;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res.count  = r_count;
        o_res.status = ST_DONE;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_y_ext[IDX_W-1:0];
        w_wr_en     = 1'b0;
        w_wr_addr   = r_clr_row;
        w_wr_data   = '0;
        case (r_state)
            BK_INIT, BK_CLEAR: begin
                w_wr_en     = 1'b1;
                n_clr_row   = r_clr_row + IDX_W'(1);
                n_fwd_valid = 1'b0;
                n_count     = '0;
                if ((r_state == BK_CLEAR) && (r_clr_row == LAST_ROW)) begin
                    o_res_push  = 1'b1;
                    o_res.count = '0;
                end
            end
            BK_IDLE: begin
                if (w_take) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_DRAW: begin
                            n_x     = i_cmd.x;
                            n_y     = i_cmd.y;
                            n_dir_x = i_cmd.dir_x;
                            n_dir_y = i_cmd.dir_y;
                            n_left  = {1'b0, i_cmd.steps} + (COORD_W + 1)'(1);
                        end
                        OP_CLEAR: begin
                            n_clr_row = '0;
                        end
                        default: begin
                            o_res_push   = 1'b1;
                            o_res.status = i_cmd.status;
                        end
                    endcase
                end
            end
            BK_WALK: begin
                // issue one cell a cycle; cells off the grid are walked past
                if (r_left != '0) begin
                    n_x        = r_x + dir_step(r_dir_x);
                    n_y        = r_y + dir_step(r_dir_y);
                    n_left     = r_left - (COORD_W + 1)'(1);
                    w_rd_en    = w_in_grid;
                    n_s2_valid = w_in_grid;
                    n_s2_col   = w_x_ext[IDX_W-1:0];
                    n_s2_row   = w_y_ext[IDX_W-1:0];
                end else if (!r_s2_valid) begin
                    o_res_push = 1'b1;
                end
                // update stage: saturating increment of the cell
                if (r_s2_valid && (w_old < 2'd2)) begin
                    w_wr_en     = 1'b1;
                    w_wr_addr   = r_s2_row;
                    w_wr_data   = w_new_row;
                    n_fwd_valid = 1'b1;
                    n_fwd_row   = r_s2_row;
                    n_fwd_data  = w_new_row;
                    if (w_old == 2'd1) n_count = r_count + COUNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_INIT;
            r_clr_row   <= '0;
            r_left      <= '0;
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_left      <= n_left;
            r_s2_valid  <= n_s2_valid;
            r_fwd_valid <= n_fwd_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_dir_x    <= n_dir_x;
        r_dir_y    <= n_dir_y;
        r_s2_col   <= n_s2_col;
        r_s2_row   <= n_s2_row;
        r_fwd_row  <= n_fwd_row;
        r_fwd_data <= n_fwd_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

endmodule

// ===== rtl/sroc_checker.sv =====
// sroc_checker: port-level checks of the segment raster overlap counter
// depends on sroc_pkg; bound to the top level at the end of this file
module sroc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [sroc_pkg::COUNT_W-1:0]  o_overlap_count,
    input logic [sroc_pkg::STATUS_W-1:0] o_status
);
    import sroc_pkg::*;

    // the grid sweep after reset holds off new items
    a_init_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> full)
        else $error("item could be taken before the grid sweep");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == ST_DONE || o_status == ST_SKIPPED
                    || o_status == ST_REJECTED))
        else $error("result carries an unknown status");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_overlap_count) && $stable(o_status)))
        else $error("waiting result changed or vanished");

    a_empty_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result queue drained without a pop");

endmodule

bind segment_raster_overlap_counter sroc_checker u_checker (.*);

// ===== sim/testbench.sv =====
// testbench for segment_raster_overlap_counter: directed table of segments, then random segments
// mostly in four hot windows; results are checked against a grid predictor or a typed table row
// depends on sroc_pkg and the rtl of segment_raster_overlap_counter
`timescale 1ns / 100ps

module testbench;
    import sroc_pkg::*;

    localparam int GRID_SIDE      = 1024;
    localparam int HOT_SPAN       = 16;
    localparam int RANDOM_PER_SET = 186;
    localparam int HOLD_CYCLES    = 600;
    localparam logic [ADDR_W-1:0] SKIP_DIAG_ADDR = {REG_SKIP_DIAG, 2'b00};

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } t_segment;

    typedef struct {
        bit          skip;
        bit          action;
        int unsigned sx;
        int unsigned sy;
        int unsigned ex;
        int unsigned ey;
        bit          typed;
        int unsigned want_count;
        t_status     want_status;
    } t_directed_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                push;
    logic                full;
    logic                i_action;
    logic [COORD_W-1:0]  i_start_x;
    logic [COORD_W-1:0]  i_start_y;
    logic [COORD_W-1:0]  i_end_x;
    logic [COORD_W-1:0]  i_end_y;
    logic                empty;
    logic                pop;
    logic [COUNT_W-1:0]  o_overlap_count;
    logic [STATUS_W-1:0] o_status;

    // predictor state: only touched cells are stored, a clear drops them all
    bit [1:0]           grid_hits [int unsigned];
    logic [COUNT_W-1:0] overlap_now;
    bit                 skip_model;

    t_result       expected_totals [$];
    t_directed_row directed_rows [24];
    int unsigned   hot_x [4];
    int unsigned   hot_y [4];
    int unsigned   n_errors;
    int unsigned   n_sent;
    int unsigned   n_results;
    int unsigned   n_clears;
    int unsigned   n_rejected;
    int unsigned   n_skipped;
    int unsigned   n_input_stalls;
    bit            sender_busy;
    bit            sink_busy;

    segment_raster_overlap_counter #(
        .GRID_DIM(GRID_SIDE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .empty          (empty),
        .pop            (pop),
        .o_overlap_count(o_overlap_count),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && push && full) n_input_stalls++;
    end

    function automatic bit count_error();
        n_errors++;
        return n_errors <= 10;
    endfunction

    function automatic int unsigned pick_gap(input bit busy);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (busy || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // walks the segment cell by cell, saturating each cell at two hits; also models clear, reject and skip
    function automatic void rasterize_segment(input t_segment s, output t_result r);
        int dx, dy, adx, ady, step_x, step_y, steps;
        int unsigned key;
        bit [1:0] h;
        r.status = ST_DONE;
        if (s.action) begin
            grid_hits.delete();
            overlap_now = '0;
            n_clears++;
        end else begin
            dx = int'(s.ex) - int'(s.sx);
            dy = int'(s.ey) - int'(s.sy);
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            step_x = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
            step_y = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
            if (dx != 0 && dy != 0 && adx != ady) begin
                r.status = ST_REJECTED;
                n_rejected++;
            end else if (dx != 0 && dy != 0 && skip_model) begin
                r.status = ST_SKIPPED;
                n_skipped++;
            end else begin
                steps = adx > ady ? adx : ady;
                for (int i = 0; i <= steps; i++) begin
                    key = (int'(s.sy) + step_y * i) * GRID_SIDE + int'(s.sx) + step_x * i;
                    h = grid_hits.exists(key) ? grid_hits[key] : 2'd0;
                    if (h < 2'd2) begin
                        h++;
                        grid_hits[key] = h;
                        if (h == 2'd2) overlap_now++;
                    end
                end
            end
        end
        r.count = overlap_now;
    endfunction

    function automatic t_segment random_segment();
        t_segment s;
        int unsigned pick, kind, bx, by, x0, y0, x1, y1, d;
        pick = $urandom_range(0, 99);
        s.action = 1'b0;
        x0 = $urandom_range(0, GRID_SIDE - 1);
        y0 = $urandom_range(0, GRID_SIDE - 1);
        x1 = $urandom_range(0, GRID_SIDE - 1);
        y1 = $urandom_range(0, GRID_SIDE - 1);
        if (pick < 3) begin
            s.action = 1'b1;
        end else if (pick < 9) begin
            // any slope other than flat, upright or 45 degrees
            while (x1 == x0) x1 = $urandom_range(0, GRID_SIDE - 1);
            d = x1 > x0 ? x1 - x0 : x0 - x1;
            while (y1 == y0 || (y1 > y0 ? y1 - y0 : y0 - y1) == d)
                y1 = $urandom_range(0, GRID_SIDE - 1);
        end else if (pick < 12) begin
            // long segment anywhere on the grid
            kind = $urandom_range(0, 2);
            if (kind == 0) begin
                y1 = y0;
            end else if (kind == 1) begin
                x1 = x0;
            end else begin
                d = x1 > x0 ? x1 - x0 : x0 - x1;
                y0 = $urandom_range(0, GRID_SIDE - 1 - d);
                y1 = y0 + d;
                if ($urandom_range(0, 1)) begin
                    y1 = y0;
                    y0 = y0 + d;
                end
            end
        end else begin
            // short segment, mostly inside a hot window, so that hits pile up
            kind = $urandom_range(0, 7);
            if (kind == 0) begin
                bx = $urandom_range(0, GRID_SIDE - 2 * HOT_SPAN);
                by = $urandom_range(0, GRID_SIDE - 2 * HOT_SPAN);
            end else begin
                bx = hot_x[kind % 4];
                by = hot_y[kind % 4];
            end
            x0 = bx + $urandom_range(0, HOT_SPAN - 1);
            y0 = by + $urandom_range(0, HOT_SPAN - 1);
            x1 = bx + $urandom_range(0, HOT_SPAN - 1);
            y1 = by + $urandom_range(0, HOT_SPAN - 1);
            kind = $urandom_range(0, 3);
            if (kind == 0) begin
                x1 = x0;
                y1 = y0;
            end else if (kind == 1) begin
                y1 = y0;
            end else if (kind == 2) begin
                x1 = x0;
            end else begin
                d = x1 > x0 ? x1 - x0 : x0 - x1;
                y1 = ($urandom_range(0, 1) && y0 >= d) ? y0 - d : y0 + d;
            end
        end
        s.sx = COORD_W'(x0);
        s.sy = COORD_W'(y0);
        s.ex = COORD_W'(x1);
        s.ey = COORD_W'(y1);
        return s;
    endfunction

    task automatic send_segment(input t_segment s, input int unsigned gap,
                                input bit typed, input t_result typed_exp);
        t_result exp;
        i_action  <= s.action;
        i_start_x <= s.sx;
        i_start_y <= s.sy;
        i_end_x   <= s.ex;
        i_end_y   <= s.ey;
        push      <= 1'b1;
        do @(posedge i_clk); while (full);
        rasterize_segment(s, exp);
        expected_totals.insert(expected_totals.size(), typed ? typed_exp : exp);
        n_sent++;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // waits for the block to drain, then writes the register and reads it back
    task automatic set_skip_diagonals(input bit value);
        logic [DATA_W-1:0] rd;
        push <= 1'b0;
        while (expected_totals.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SKIP_DIAG_ADDR;
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        skip_model = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== DATA_W'(value)) begin
            if (count_error())
                $display("skip_diagonals reads back %0h, expected %0h", rd, value);
        end
    endtask

    initial begin : segment_source
        t_segment seg;
        t_result  typed_exp;
        i_rst_n   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        push      <= 1'b0;
        i_action  <= 1'b0;
        i_start_x <= '0;
        i_start_y <= '0;
        i_end_x   <= '0;
        i_end_y   <= '0;
        overlap_now = '0;
        directed_rows = '{
            '{0, 0,    0,    0,    0,    0, 1, 0, ST_DONE},     // single point
            '{0, 0,    0,    0,    0,    0, 1, 1, ST_DONE},     // same point again
            '{0, 0, 1023, 1023,    0, 1023, 0, 0, ST_DONE},     // whole bottom row, leftward
            '{0, 0, 1023,    0, 1023, 1023, 0, 0, ST_DONE},     // whole right column
            '{0, 0,    0,    0, 1023, 1023, 0, 0, ST_DONE},     // main diagonal
            '{0, 0, 1023,    0,    0, 1023, 0, 0, ST_DONE},     // anti diagonal
            '{0, 0,    0,    0,    2,    1, 0, 0, ST_DONE},     // bad slope
            '{0, 0, 1023,    0,    0,    1, 0, 0, ST_DONE},     // bad slope, long
            '{0, 0,   10,   10,    5,    5, 0, 0, ST_DONE},
            '{0, 0,    5,   10,   10,    5, 0, 0, ST_DONE},
            '{0, 0,   20,    3,   10,    3, 0, 0, ST_DONE},
            '{0, 0,    7,   30,    7,   20, 0, 0, ST_DONE},
            '{0, 1, 1023, 1023, 1023, 1023, 1, 0, ST_DONE},     // clear ignores coordinates
            '{0, 0,  512,  511,  512,  511, 1, 0, ST_DONE},
            '{0, 0,  512,  511,  512,  511, 1, 1, ST_DONE},
            '{0, 0,  512,  511,  512,  511, 1, 1, ST_DONE},     // saturated cell
            '{0, 0,    1,    0, 1023, 1023, 1, 1, ST_REJECTED},
            '{1, 0,    0,    0,    3,    3, 1, 1, ST_SKIPPED},
            '{1, 0,    3,    3,    0,    0, 1, 1, ST_SKIPPED},
            '{1, 0,    4,    4,    4,    4, 1, 1, ST_DONE},     // point is drawn while skipping
            '{1, 0,    0,    4,    8,    4, 0, 0, ST_DONE},
            '{1, 0,    0,    0,    1,    2, 0, 0, ST_DONE},     // bad slope wins over skip
            '{1, 1,    0,    0,    0,    0, 1, 0, ST_DONE},
            '{0, 0,    0,    5,    5,    0, 0, 0, ST_DONE}
        };
        foreach (hot_x[h]) begin
            hot_x[h] = $urandom_range(0, GRID_SIDE - 2 * HOT_SPAN);
            hot_y[h] = $urandom_range(0, GRID_SIDE - 2 * HOT_SPAN);
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_skip_diagonals(1'b0);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].skip != skip_model) set_skip_diagonals(directed_rows[r].skip);
            seg.action = directed_rows[r].action;
            seg.sx = COORD_W'(directed_rows[r].sx);
            seg.sy = COORD_W'(directed_rows[r].sy);
            seg.ex = COORD_W'(directed_rows[r].ex);
            seg.ey = COORD_W'(directed_rows[r].ey);
            typed_exp.count  = COUNT_W'(directed_rows[r].want_count);
            typed_exp.status = directed_rows[r].want_status;
            send_segment(seg, pick_gap(1'b0), directed_rows[r].typed, typed_exp);
        end

        for (int set = 0; set < 3; set++) begin
            set_skip_diagonals(set == 1);
            for (int n = 0; n < RANDOM_PER_SET; n++) begin
                if (n % 40 == 0) sender_busy = ($urandom_range(0, 3) == 0);
                send_segment(random_segment(), pick_gap(sender_busy), 1'b0, typed_exp);
            end
        end

        push <= 1'b0;
        while (expected_totals.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        $display("%0d segment items, %0d results checked (%0d clears, %0d bad slopes, %0d skipped)",
                 n_sent, n_results, n_clears, n_rejected, n_skipped);
        $display("diagonal skipping off and on, input held off for %0d cycles in all",
                 n_input_stalls);
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin : result_sink
        t_result     want;
        int unsigned idle;
        pop <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        pop <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                n_results++;
                if (expected_totals.size() == 0) begin
                    if (count_error())
                        $display("unexpected result: overlap_count %0d status %0d",
                                 o_overlap_count, o_status);
                end else begin
                    want = expected_totals.pop_front();
                    if (o_overlap_count !== want.count) begin
                        if (count_error())
                            $display("result %0d: overlap_count %0d, expected %0d",
                                     n_results, o_overlap_count, want.count);
                    end
                    if (o_status !== want.status) begin
                        if (count_error())
                            $display("result %0d: status %0d, expected %0d",
                                     n_results, o_status, want.status);
                    end
                end
                if (n_results % 50 == 0) sink_busy = ($urandom_range(0, 3) == 0);
                // two long hold-offs let the block fill up and push back on the input
                idle = (n_results == 120 || n_results == 360) ? HOLD_CYCLES : pick_gap(sink_busy);
                if (idle != 0) begin
                    pop <= 1'b0;
                    repeat (idle) @(posedge i_clk);
                    pop <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sim.f =====
rtl/sroc_pkg.sv
rtl/sroc_fifo.sv
rtl/sroc_front.sv
rtl/sroc_back.sv
rtl/segment_raster_overlap_counter.sv
rtl/sroc_checker.sv
sim/testbench.sv
